// File: design/cloud_in_cell_charge_deposit_top_defines.svh
// Assertion macros for the cloud-in-cell charge deposit block.
// Used by the checker module; relies on clk and rst_n in the including scope.
`ifndef CLOUD_IN_CELL_CHARGE_DEPOSIT_TOP_DEFINES_SVH
`define CLOUD_IN_CELL_CHARGE_DEPOSIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccd check failed");

`endif

// File: design/ccd_pkg.sv
// Shared types and constants for the cloud-in-cell charge deposit block.
// No dependencies; used by the top level and the checker.
package ccd_pkg;

  localparam int GRID_POINTS_DEF = 64;
  localparam int ACC_W           = 48;
  localparam int POS_W           = 32;
  localparam int CHG_W           = 32;
  localparam int RC_W            = 6;
  localparam int SHIFT_W         = 5;
  localparam int FRAC_W          = 16;
  localparam int WGT_W           = 33;
  localparam int PROD_W          = 66;
  localparam logic [SHIFT_W-1:0] CELL_SHIFT_RST = 5'd16;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_DEPOSIT = 2'd1,
    REQ_FOLD    = 2'd2,
    REQ_READ    = 2'd3
  } ccd_req_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DEP_SETUP,
    ST_DEP_RUN,
    ST_FOLD,
    ST_READ,
    ST_READ_WAIT
  } ccd_state_t;

  // Fraction of a position brought to 16 bits.
  function automatic logic [FRAC_W-1:0] frac16(input logic [POS_W-1:0] pos,
                                               input logic [SHIFT_W-1:0] cs);
    logic [POS_W-1:0] mask;
    logic [POS_W-1:0] fr;
    logic [POS_W-1:0] sh;
    mask = ~({POS_W{1'b1}} << cs);
    fr   = pos & mask;
    if (cs >= SHIFT_W'(FRAC_W)) begin
      sh = fr >> (cs - SHIFT_W'(FRAC_W));
    end else begin
      sh = fr << (SHIFT_W'(FRAC_W) - cs);
    end
    return sh[FRAC_W-1:0];
  endfunction

endpackage

// File: design/ccd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ccd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/cloud_in_cell_charge_deposit_top.sv
// Top level of the cloud-in-cell charge deposit block.
// Depends on ccd_pkg and ccd_ram.
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------------
//  input     start, busy            in_req_type, in_pos_x/y, in_charge, in_read_*
//  result    out_strobe (1 cycle)   out_status, out_cell_value
//  config    cfg_we                 cfg_data (cell_shift)
//
// A read passes through a read state and a wait state. A deposit has a setup state and,
// unless rejected, then streams four corner read-modify-writes through the single grid
// RAM port pair. A fold walks 2*GRID_POINTS edge pairs, each two reads and two writes.
// A clear, and the pass that follows reset, write zero to every cell at one a cycle,
// with busy high throughout.
// The result beat appears in the first cycle with busy low; the receiver cannot stall.
module cloud_in_cell_charge_deposit_top #(
  parameter int GRID_POINTS = ccd_pkg::GRID_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_req_type,
  input  logic [ccd_pkg::POS_W-1:0]        in_pos_x,
  input  logic [ccd_pkg::POS_W-1:0]        in_pos_y,
  input  logic signed [ccd_pkg::CHG_W-1:0] in_charge,
  input  logic [ccd_pkg::RC_W-1:0]         in_read_row,
  input  logic [ccd_pkg::RC_W-1:0]         in_read_col,
  input  logic                             cfg_we,
  input  logic [ccd_pkg::SHIFT_W-1:0]      cfg_data,
  output logic                             out_strobe,
  output logic                             out_status,
  output logic signed [ccd_pkg::ACC_W-1:0] out_cell_value
);

  localparam int CELLS  = GRID_POINTS * GRID_POINTS;
  localparam int IDX_W  = $clog2(GRID_POINTS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PAIR_W = $clog2(2 * GRID_POINTS);
  localparam int ACC_W  = ccd_pkg::ACC_W;

  // Row-major cell address; row and column carry one extra bit for the +1 corner.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W:0] row,
                                                  input logic [IDX_W:0] col);
    return ADDR_W'(int'(row) * GRID_POINTS + int'(col));
  endfunction

  ccd_pkg::ccd_state_t state_r, state_nxt;

  logic [ccd_pkg::SHIFT_W-1:0] cell_shift_r;
  logic [2:0]                  cyc_r, cyc_nxt;
  logic [PAIR_W-1:0]           pc_r, pc_nxt;
  logic [ADDR_W-1:0]           sweep_addr_r, sweep_addr_nxt;
  logic                        sweep_report_r, sweep_report_nxt;

  // Latched request payload.
  logic [ccd_pkg::POS_W-1:0]        px_r, py_r;
  logic signed [ccd_pkg::CHG_W-1:0] chg_r;
  logic [ccd_pkg::RC_W-1:0]         rrow_r, rcol_r;

  // Deposit setup results and corner pipeline.
  logic [IDX_W-1:0]                  ii_r, jj_r;
  logic [ccd_pkg::FRAC_W-1:0]        fx_r, fy_r;
  logic [ccd_pkg::WGT_W-1:0]         w_r, w_nxt;
  logic [ADDR_W-1:0]                 a_addr_r, a_addr_nxt, b_addr_r;
  logic signed [ccd_pkg::PROD_W-1:0] prod_r;

  // Fold holding registers.
  logic [ACC_W-1:0] fa_r, fa_nxt, favg_r, favg_nxt;

  logic             out_strobe_r, out_strobe_nxt;
  logic             out_status_r, out_status_nxt;
  logic [ACC_W-1:0] out_value_r, out_value_nxt;

  // RAM port.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ACC_W-1:0]  ram_wdata, ram_rdata;

  ccd_ram #(
    .WIDTH(ACC_W),
    .DEPTH(CELLS)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ccd_pkg::ST_IDLE);

  // Cell index and rejection, computed in the setup cycle from the latched position.
  logic [ccd_pkg::POS_W-1:0] ix, iy;
  logic                      reject;
  assign ix     = px_r >> cell_shift_r;
  assign iy     = py_r >> cell_shift_r;
  assign reject = (ix > ccd_pkg::POS_W'(GRID_POINTS - 2)) ||
                  (iy > ccd_pkg::POS_W'(GRID_POINTS - 2));

  logic sweep_last, fold_last;
  assign sweep_last = (sweep_addr_r == ADDR_W'(CELLS - 1));
  assign fold_last  = (pc_r == PAIR_W'(2 * GRID_POINTS - 1));

  // Corner pipeline: stage A forms the weight product and address, stage B reads
  // the cell and multiplies by charge, stage C rounds, adds with saturation and
  // writes back; each corner passes through A, B and C in turn.
  // The four corners are distinct cells, so stage B never reads what C writes.
  logic [1:0]                corner;
  logic [ccd_pkg::FRAC_W:0]  wx1, wx0, wy1, wy0, wx_sel, wy_sel;
  logic [2*ccd_pkg::FRAC_W+1:0] wprod;
  logic signed [ccd_pkg::PROD_W-1:0] prod_rnd;
  logic signed [33:0]        dep_v;
  logic signed [ACC_W:0]     dep_sum;
  logic [ACC_W-1:0]          dep_sat;

  assign corner = cyc_r[1:0];
  assign wx1    = {1'b0, fx_r};
  assign wy1    = {1'b0, fy_r};
  assign wx0    = 17'h10000 - wx1;
  assign wy0    = 17'h10000 - wy1;
  assign wx_sel = corner[1] ? wx1 : wx0;
  assign wy_sel = corner[0] ? wy1 : wy0;
  assign wprod  = {17'b0, wx_sel} * {17'b0, wy_sel};

  // Round half up: add half an LSB, then floor by taking the upper bits.
  assign prod_rnd = prod_r + ccd_pkg::PROD_W'(64'sh8000_0000);
  assign dep_v    = prod_rnd[65:32];
  assign dep_sum  = {ram_rdata[ACC_W-1], ram_rdata} + {{15{dep_v[33]}}, dep_v};

  always_comb begin
    if (dep_sum[ACC_W] != dep_sum[ACC_W-1]) begin
      dep_sat = dep_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      dep_sat = dep_sum[ACC_W-1:0];
    end
  end

  // Fold edge pair: the first half of the pairs covers rows, the second columns.
  logic [IDX_W-1:0]  fold_u;
  logic [ADDR_W-1:0] fold_a_addr, fold_b_addr;
  logic [PAIR_W-1:0] pc_col;
  logic              fold_rows;
  logic [ACC_W:0]    fold_sum;
  logic [ACC_W-1:0]  fold_avg;

  assign fold_rows   = (pc_r < PAIR_W'(GRID_POINTS));
  assign pc_col      = pc_r - PAIR_W'(GRID_POINTS);
  assign fold_u      = fold_rows ? pc_r[IDX_W-1:0] : pc_col[IDX_W-1:0];
  assign fold_a_addr = fold_rows ?
                       cell_addr((IDX_W+1)'(GRID_POINTS - 1), {1'b0, fold_u}) :
                       cell_addr({1'b0, fold_u}, (IDX_W+1)'(GRID_POINTS - 1));
  assign fold_b_addr = fold_rows ?
                       cell_addr('0, {1'b0, fold_u}) :
                       cell_addr({1'b0, fold_u}, '0);
  // Average rounded toward minus infinity: arithmetic halving of the wide sum.
  assign fold_sum    = {fa_r[ACC_W-1], fa_r} + {ram_rdata[ACC_W-1], ram_rdata};
  assign fold_avg    = fold_sum[ACC_W:1];

  logic       read_in_range;
  assign read_in_range = (int'(rrow_r) < GRID_POINTS) && (int'(rcol_r) < GRID_POINTS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccd_pkg::ST_SWEEP: begin
        if (sweep_last) state_nxt = ccd_pkg::ST_IDLE;
      end
      ccd_pkg::ST_IDLE: begin
        if (start) begin
          case (ccd_pkg::ccd_req_t'(in_req_type))
            ccd_pkg::REQ_CLEAR:   state_nxt = ccd_pkg::ST_SWEEP;
            ccd_pkg::REQ_DEPOSIT: state_nxt = ccd_pkg::ST_DEP_SETUP;
            ccd_pkg::REQ_FOLD:    state_nxt = ccd_pkg::ST_FOLD;
            ccd_pkg::REQ_READ:    state_nxt = ccd_pkg::ST_READ;
            default:              state_nxt = ccd_pkg::ST_IDLE;
          endcase
        end
      end
      ccd_pkg::ST_DEP_SETUP: begin
        state_nxt = reject ? ccd_pkg::ST_IDLE : ccd_pkg::ST_DEP_RUN;
      end
      ccd_pkg::ST_DEP_RUN: begin
        if (cyc_r == 3'd5) state_nxt = ccd_pkg::ST_IDLE;
      end
      ccd_pkg::ST_FOLD: begin
        if (cyc_r[1:0] == 2'd3 && fold_last) state_nxt = ccd_pkg::ST_IDLE;
      end
      ccd_pkg::ST_READ:      state_nxt = ccd_pkg::ST_READ_WAIT;
      ccd_pkg::ST_READ_WAIT: state_nxt = ccd_pkg::ST_IDLE;
      default:               state_nxt = ccd_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls, counters and result beat.
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = sweep_addr_r;
    ram_wdata        = '0;
    ram_raddr        = a_addr_r;
    cyc_nxt          = cyc_r + 3'd1;
    pc_nxt           = pc_r;
    sweep_addr_nxt   = sweep_addr_r;
    sweep_report_nxt = sweep_report_r;
    w_nxt            = wprod[ccd_pkg::WGT_W-1:0];
    a_addr_nxt       = cell_addr({1'b0, ii_r} + (IDX_W+1)'(corner[1]),
                                 {1'b0, jj_r} + (IDX_W+1)'(corner[0]));
    fa_nxt           = fa_r;
    favg_nxt         = favg_r;
    out_strobe_nxt   = 1'b0;
    out_status_nxt   = 1'b0;
    out_value_nxt    = '0;
    case (state_r)
      ccd_pkg::ST_SWEEP: begin
        ram_we         = 1'b1;
        sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
        if (sweep_last) begin
          out_strobe_nxt   = sweep_report_r;
          sweep_report_nxt = 1'b0;
        end
      end
      ccd_pkg::ST_IDLE: begin
        cyc_nxt        = '0;
        pc_nxt         = '0;
        sweep_addr_nxt = '0;
        if (start && ccd_pkg::ccd_req_t'(in_req_type) == ccd_pkg::REQ_CLEAR) begin
          sweep_report_nxt = 1'b1;
        end
      end
      ccd_pkg::ST_DEP_SETUP: begin
        cyc_nxt = '0;
        if (reject) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = 1'b1;
        end
      end
      ccd_pkg::ST_DEP_RUN: begin
        ram_raddr = a_addr_r;
        if (cyc_r >= 3'd2) begin
          ram_we    = 1'b1;
          ram_waddr = b_addr_r;
          ram_wdata = dep_sat;
        end
        if (cyc_r == 3'd5) out_strobe_nxt = 1'b1;
      end
      ccd_pkg::ST_FOLD: begin
        case (cyc_r[1:0])
          2'd0: ram_raddr = fold_a_addr;
          2'd1: begin
            ram_raddr = fold_b_addr;
            fa_nxt    = ram_rdata;
          end
          2'd2: begin
            ram_we    = 1'b1;
            ram_waddr = fold_a_addr;
            ram_wdata = fold_avg;
            favg_nxt  = fold_avg;
          end
          default: begin
            ram_we    = 1'b1;
            ram_waddr = fold_b_addr;
            ram_wdata = favg_r;
            cyc_nxt   = '0;
            pc_nxt    = pc_r + PAIR_W'(1);
            if (fold_last) out_strobe_nxt = 1'b1;
          end
        endcase
      end
      ccd_pkg::ST_READ: begin
        ram_raddr = cell_addr((IDX_W+1)'(rrow_r), (IDX_W+1)'(rcol_r));
      end
      ccd_pkg::ST_READ_WAIT: begin
        out_strobe_nxt = 1'b1;
        out_value_nxt  = read_in_range ? ram_rdata : '0;
      end
      default: begin
        cyc_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ccd_pkg::ST_SWEEP;
      cyc_r          <= '0;
      pc_r           <= '0;
      sweep_addr_r   <= '0;
      sweep_report_r <= 1'b0;
      cell_shift_r   <= ccd_pkg::CELL_SHIFT_RST;
      out_strobe_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cyc_r          <= cyc_nxt;
      pc_r           <= pc_nxt;
      sweep_addr_r   <= sweep_addr_nxt;
      sweep_report_r <= sweep_report_nxt;
      out_strobe_r   <= out_strobe_nxt;
      if (cfg_we) cell_shift_r <= cfg_data;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      chg_r  <= in_charge;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    if (state_r == ccd_pkg::ST_DEP_SETUP) begin
      ii_r <= ix[IDX_W-1:0];
      jj_r <= iy[IDX_W-1:0];
      fx_r <= ccd_pkg::frac16(px_r, cell_shift_r);
      fy_r <= ccd_pkg::frac16(py_r, cell_shift_r);
    end
    w_r          <= w_nxt;
    a_addr_r     <= a_addr_nxt;
    b_addr_r     <= a_addr_r;
    prod_r       <= chg_r * $signed({1'b0, w_r});
    fa_r         <= fa_nxt;
    favg_r       <= favg_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_cell_value = out_value_r;

endmodule

// File: design/ccd_checker.sv
// Port-level checker for the cloud-in-cell charge deposit block, with its bind.
// Depends on ccd_pkg and the assertion macros header.
`include "cloud_in_cell_charge_deposit_top_defines.svh"

module ccd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic                        out_status,
  input logic [ccd_pkg::ACC_W-1:0]   out_cell_value
);

  // An accepted request always makes the block busy in the next cycle.
  `CCD_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // Every result beat is issued as the block returns to idle.
  `CCD_ASSERT_IMP(a_beat_idle, out_strobe, !busy)
  // Result beats are single cycles and never come back to back.
  `CCD_ASSERT_NXT(a_beat_single, out_strobe, !out_strobe)
  // A rejected deposit reports no cell value.
  `CCD_ASSERT_IMP(a_reject_zero, out_strobe && out_status, out_cell_value == '0)

endmodule

bind cloud_in_cell_charge_deposit_top ccd_checker u_ccd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_status    (out_status),
  .out_cell_value(out_cell_value)
);

// File: sim/ccd_checker.sv
// Watches the command and result channels of the charge deposit block, predicts each result.
// Depends on ccd_pkg; reports its mismatch count to the testbench top.
`timescale 1ns / 100ps

module ccd_scoreboard #(
  parameter int GRID_POINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic [1:0]                       in_req_type,
  input  logic [ccd_pkg::POS_W-1:0]        in_pos_x,
  input  logic [ccd_pkg::POS_W-1:0]        in_pos_y,
  input  logic signed [ccd_pkg::CHG_W-1:0] in_charge,
  input  logic [ccd_pkg::RC_W-1:0]         in_read_row,
  input  logic [ccd_pkg::RC_W-1:0]         in_read_col,
  input  logic                             cfg_we,
  input  logic [ccd_pkg::SHIFT_W-1:0]      cfg_data,
  input  logic                             out_strobe,
  input  logic                             out_status,
  input  logic signed [ccd_pkg::ACC_W-1:0] out_cell_value,
  output int                               fail_count,
  output int                               pending
);

  typedef struct packed {
    logic                             status;
    logic signed [ccd_pkg::ACC_W-1:0] value;
  } deposit_result_t;

  localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< 47);

  longint          density [GRID_POINTS*GRID_POINTS];
  logic [4:0]      shift_model;
  deposit_result_t expected_results[$];

  initial pending = 0;

  function automatic longint fraction_weight(logic [31:0] pos);
    longint fr;
    fr = longint'(pos) & ((64'sd1 <<< shift_model) - 1);
    if (shift_model >= 16) return fr >>> (shift_model - 16);
    return fr <<< (16 - shift_model);
  endfunction

  // Charge times weight over 2^32, rounded half up.
  function automatic longint share_of(longint chg, longint w);
    return (chg * w + (64'sd1 <<< 31)) >>> 32;
  endfunction

  task automatic accumulate(int row, int col, longint v);
    longint s;
    s = density[row*GRID_POINTS + col] + v;
    if (s > ACC_HI) s = ACC_HI;
    if (s < ACC_LO) s = ACC_LO;
    density[row*GRID_POINTS + col] = s;
  endtask

  task automatic apply_request(output deposit_result_t r);
    longint i, j, wx1, wy1, wx0, wy0, chg, a;
    int     last;
    last = GRID_POINTS - 1;
    r = '0;
    chg = longint'(in_charge);
    case (ccd_pkg::ccd_req_t'(in_req_type))
      ccd_pkg::REQ_CLEAR: foreach (density[k]) density[k] = 0;
      ccd_pkg::REQ_DEPOSIT: begin
        i = longint'(in_pos_x) >> shift_model;
        j = longint'(in_pos_y) >> shift_model;
        if (i > GRID_POINTS - 2 || j > GRID_POINTS - 2) begin
          r.status = 1'b1;
        end else begin
          wx1 = fraction_weight(in_pos_x);
          wy1 = fraction_weight(in_pos_y);
          wx0 = 65536 - wx1;
          wy0 = 65536 - wy1;
          accumulate(i, j, share_of(chg, wx0 * wy0));
          accumulate(i, j + 1, share_of(chg, wx0 * wy1));
          accumulate(i + 1, j, share_of(chg, wx1 * wy0));
          accumulate(i + 1, j + 1, share_of(chg, wx1 * wy1));
        end
      end
      ccd_pkg::REQ_FOLD: begin
        // Rows first, then columns; the average rounds toward minus infinity.
        for (int u = 0; u < GRID_POINTS; u++) begin
          a = (density[last*GRID_POINTS + u] + density[u]) >>> 1;
          density[last*GRID_POINTS + u] = a;
          density[u] = a;
        end
        for (int u = 0; u < GRID_POINTS; u++) begin
          a = (density[u*GRID_POINTS + last] + density[u*GRID_POINTS]) >>> 1;
          density[u*GRID_POINTS + last] = a;
          density[u*GRID_POINTS] = a;
        end
      end
      default: begin
        if (in_read_row < GRID_POINTS && in_read_col < GRID_POINTS)
          r.value = density[in_read_row*GRID_POINTS + in_read_col][ccd_pkg::ACC_W-1:0];
      end
    endcase
  endtask

  always @(posedge clk) begin
    deposit_result_t r, e;
    if (!rst_n) begin
      foreach (density[k]) density[k] = 0;
      shift_model = ccd_pkg::CELL_SHIFT_RST;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) shift_model = cfg_data;
      if (start && !busy) begin
        apply_request(r);
        expected_results = {expected_results, r};
      end
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          e = expected_results.pop_front();
          if (e.status !== out_status || e.value !== out_cell_value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch at %0t: expected status %0d value %0d, got %0d %0d",
                       $realtime, e.status, e.value, out_status, out_cell_value);
          end
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

// File: sim/tb_top.sv
// Testbench top for the cloud-in-cell charge deposit block: stimulus and verdict.
// Depends on ccd_pkg, the block and ccd_scoreboard.
`timescale 1ns / 100ps

module tb_top;

  localparam int GRID = 64;
  // A clear walks all 4096 cells and a fold every edge pair. Allow several times the longer.
  localparam int IDLE_LIMIT = 40000;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic [1:0]                       in_req_type = '0;
  logic [ccd_pkg::POS_W-1:0]        in_pos_x = '0;
  logic [ccd_pkg::POS_W-1:0]        in_pos_y = '0;
  logic signed [ccd_pkg::CHG_W-1:0] in_charge = '0;
  logic [ccd_pkg::RC_W-1:0]         in_read_row = '0;
  logic [ccd_pkg::RC_W-1:0]         in_read_col = '0;
  logic                             cfg_we = 1'b0;
  logic [ccd_pkg::SHIFT_W-1:0]      cfg_data = '0;
  logic                             out_strobe;
  logic                             out_status;
  logic signed [ccd_pkg::ACC_W-1:0] out_cell_value;
  int                               fail_count;
  int                               pending;
  int                               idle_cycles = 0;
  logic [ccd_pkg::SHIFT_W-1:0]      shift_now = ccd_pkg::CELL_SHIFT_RST;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cloud_in_cell_charge_deposit_top #(.GRID_POINTS(GRID)) dut (.*);

  ccd_scoreboard #(.GRID_POINTS(GRID)) checker_i (.*);

  // Watchdog: counts cycles in which neither a command nor a result beat is accepted.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("cloud_in_cell_charge_deposit_top test failed");
      $finish;
    end
  end

  // Builds a position whose cell index is below the grid edge for the current shift.
  function automatic logic [31:0] inner_pos();
    logic [31:0] p;
    p = $urandom;
    p = p & ((32'd1 << shift_now) - 1);
    return p | (32'($urandom_range(0, GRID - 2)) << shift_now);
  endfunction

  // Drives one command beat at a falling edge and holds it until the block takes it.
  // Busy is stable at the falling edge, so low there means the next rising edge accepts.
  task automatic send(ccd_pkg::ccd_req_t req, logic [31:0] px, logic [31:0] py,
                      logic [31:0] chg, logic [5:0] rr, logic [5:0] rc);
    in_req_type = req;
    in_pos_x    = px;
    in_pos_y    = py;
    in_charge   = chg;
    in_read_row = rr;
    in_read_col = rc;
    start       = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic sender_gap(bit bursty);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 6);
    repeat (gap) @(negedge clk);
  endtask

  // Waits out every outstanding result, then lets the block settle before a register write.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_shift(logic [4:0] s);
    drain();
    cfg_data  = s;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    shift_now = s;
  endtask

  task automatic random_item(bit bursty);
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 70)
      send(ccd_pkg::REQ_DEPOSIT, inner_pos(), inner_pos(), $urandom,
           6'($urandom), 6'($urandom));
    else if (kind < 78)
      send(ccd_pkg::REQ_DEPOSIT, $urandom, $urandom, $urandom, 6'($urandom), 6'($urandom));
    else if (kind < 96)
      send(ccd_pkg::REQ_READ, $urandom, $urandom, $urandom, 6'($urandom), 6'($urandom));
    else if (kind < 99)
      send(ccd_pkg::REQ_FOLD, $urandom, $urandom, $urandom, 6'($urandom), 6'($urandom));
    else
      send(ccd_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, 6'($urandom), 6'($urandom));
    sender_gap(bursty);
  endtask

  initial begin
    logic [4:0] shifts[6];
    bit         bursty;
    shifts = '{5'd16, 5'd0, 5'd31, 5'd10, 5'd20, 5'd5};

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed beats: corners, edges of the grid, extremes of the charge, every request.
    send(ccd_pkg::REQ_DEPOSIT, 32'h0000_8000, 32'h0000_4000, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send(ccd_pkg::REQ_DEPOSIT, 32'h003E_FFFF, 32'h003E_FFFF, 32'h8000_0000, 6'd0, 6'd0);
    send(ccd_pkg::REQ_DEPOSIT, 32'h003F_0000, 32'h0000_0000, 32'h0001_0000, 6'd0, 6'd0);
    send(ccd_pkg::REQ_DEPOSIT, 32'h0000_0000, 32'h003F_0000, 32'h0001_0000, 6'd0, 6'd0);
    send(ccd_pkg::REQ_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send(ccd_pkg::REQ_DEPOSIT, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send(ccd_pkg::REQ_READ, '0, '0, '0, 6'd0, 6'd0);
    send(ccd_pkg::REQ_READ, '0, '0, '0, 6'd63, 6'd63);
    send(ccd_pkg::REQ_READ, '0, '0, '0, 6'd0, 6'd1);
    // Drive one cell with repeated full charges; the sum stays well below saturation.
    repeat (8)
      send(ccd_pkg::REQ_DEPOSIT, 32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send(ccd_pkg::REQ_READ, '0, '0, '0, 6'd1, 6'd1);
    send(ccd_pkg::REQ_FOLD, '0, '0, '0, 6'd0, 6'd0);
    send(ccd_pkg::REQ_READ, '0, '0, '0, 6'd63, 6'd0);
    send(ccd_pkg::REQ_CLEAR, '0, '0, '0, 6'd0, 6'd0);
    send(ccd_pkg::REQ_READ, '0, '0, '0, 6'd1, 6'd1);

    // Random phases, one per cell shift, including both extremes.
    foreach (shifts[p]) begin
      set_shift(shifts[p]);
      for (int n = 0; n < 150; n++) begin
        bursty = (n % 50) < 12;
        random_item(bursty);
        // The sender sometimes holds off until every result is back.
        if (n == 75) while (pending != 0) @(negedge clk);
      end
    end

    drain();
    if (fail_count == 0) $display("cloud_in_cell_charge_deposit_top test passed");
    else $display("cloud_in_cell_charge_deposit_top test failed");
    $finish;
  end
endmodule
